// ----- rtl/odtp_pkg.sv -----
package odtp_pkg;

    localparam int CordicStagesDef = 16;
    localparam int CordicMaxStages = 24;

    localparam logic [7:0]  DistGainRst  = 8'd20;
    localparam logic [15:0] HeadGainRst  = 16'd2000;
    localparam logic [7:0]  EffLimitRst  = 8'd150;
    localparam logic [15:0] ReachRst     = 16'd768;

    localparam logic [1:0] RegDistGain  = 2'd0;
    localparam logic [1:0] RegHeadGain  = 2'd1;
    localparam logic [1:0] RegEffLimit  = 2'd2;
    localparam logic [1:0] RegReach     = 2'd3;

    // CORDIC gain in Q30, pi in Q24
    localparam logic signed [31:0] KQ30  = 32'sd652032874;
    localparam logic signed [27:0] PiQ24 = 28'sd52707179;

    localparam int AW = 34;   // angle accumulator width
    localparam int DW = 40;   // datapath x/y width

    function automatic logic signed [AW-1:0] atan_rom(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return AW'(signed'({1'b0, v}));
    endfunction

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_ROTI   = 10'b0000000010,
        S_ROT    = 10'b0000000100,
        S_POSE   = 10'b0000001000,
        S_VECI   = 10'b0000010000,
        S_VEC    = 10'b0000100000,
        S_MAG    = 10'b0001000000,
        S_ERRI   = 10'b0010000000,
        S_EFF    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE, OP_ROT_INIT_MID, OP_ROT_INIT_ERR, OP_ITER, OP_POSE, OP_VEC_INIT,
        OP_MAG, OP_EFF
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       vec_mode;
        logic [4:0] iter;
        logic [2:0] sub;
        logic       load_goal;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic       driving;
        logic       zero_vec;
    } t_status;

endpackage

// ----- rtl/odometry_drive_to_point.sv -----
// Each motion item while driving runs a CORDIC rotation, the pose update, a CORDIC
// vectoring to the goal, the range step, a second rotation and the drive effort; a
// motion item while idle stops after the range step; a set-goal item starts at the
// vectoring. One shared iterative CORDIC serves all of them. A new item is taken
// only once the controller is idle and the previous result has been transferred.
// Reset (i_rst_n low, synchronous): pose, laps, goal cleared, driving off,
// registers to their defaults, no result pending.
module odometry_drive_to_point #(
    parameter int CORDIC_STAGES = odtp_pkg::CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_kind,
    input  logic signed [11:0] i_step_distance,
    input  logic signed [12:0] i_turn_angle,
    input  logic signed [23:0] i_goal_x,
    input  logic signed [23:0] i_goal_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [8:0]  o_left_drive,
    output logic signed [8:0]  o_right_drive,
    output logic               o_at_goal,
    output logic               o_is_driving,
    output logic signed [23:0] o_now_x,
    output logic signed [23:0] o_now_y,
    output logic signed [15:0] o_now_heading,
    output logic [15:0]        o_laps,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    logic [7:0]  r_dist_gain, r_eff_limit;
    logic [15:0] r_head_gain, r_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_gain <= odtp_pkg::DistGainRst;
            r_head_gain <= odtp_pkg::HeadGainRst;
            r_eff_limit <= odtp_pkg::EffLimitRst;
            r_reach     <= odtp_pkg::ReachRst;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                odtp_pkg::RegDistGain: r_dist_gain <= i_cfg_data[7:0];
                odtp_pkg::RegHeadGain: r_head_gain <= i_cfg_data;
                odtp_pkg::RegEffLimit: r_eff_limit <= i_cfg_data[7:0];
                odtp_pkg::RegReach:    r_reach     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    odtp_pkg::t_cmd    w_cmd;
    odtp_pkg::t_status w_stat;

    odtp_ctrl #(.CORDIC_STAGES(CORDIC_STAGES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    odtp_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_kind(i_kind), .i_step_distance(i_step_distance), .i_turn_angle(i_turn_angle),
        .i_goal_x(i_goal_x), .i_goal_y(i_goal_y),
        .i_dist_gain(r_dist_gain), .i_head_gain(r_head_gain),
        .i_eff_limit(r_eff_limit), .i_reach(r_reach),
        .o_left_drive(o_left_drive), .o_right_drive(o_right_drive),
        .o_at_goal(o_at_goal), .o_is_driving(o_is_driving),
        .o_now_x(o_now_x), .o_now_y(o_now_y),
        .o_now_heading(o_now_heading), .o_laps(o_laps)
    );

endmodule

// ----- rtl/odtp_ctrl.sv -----
module odtp_ctrl #(
    parameter int CORDIC_STAGES = odtp_pkg::CordicStagesDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  odtp_pkg::t_status i_stat,
    output odtp_pkg::t_cmd    o_cmd
);
    localparam int NS = (CORDIC_STAGES > odtp_pkg::CordicMaxStages) ? odtp_pkg::CordicMaxStages :
                        ((CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES);

    odtp_pkg::t_state r_state, n_state;
    logic [4:0] r_iter, n_iter;
    logic [2:0] r_sub, n_sub;
    logic       r_ovalid, n_ovalid;

    // Output register frees the core once loaded; a new transfer waits for it to drain.
    assign o_ready = (r_state == odtp_pkg::S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_sub    = r_sub;
        n_ovalid = r_ovalid && !i_ready;
        o_cmd.op = odtp_pkg::OP_NONE;
        o_cmd.vec_mode = 1'b0;
        o_cmd.iter = r_iter;
        o_cmd.sub = r_sub;
        o_cmd.load_goal = 1'b0;
        case (r_state)
            odtp_pkg::S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load_goal = 1'b1;
                    n_state = odtp_pkg::S_ROTI;
                end
            end
            odtp_pkg::S_ROTI: begin
                if (i_stat.kind) begin
                    o_cmd.op = odtp_pkg::OP_ROT_INIT_MID;
                    n_iter = '0;
                    n_state = odtp_pkg::S_ROT;
                end else begin
                    n_state = odtp_pkg::S_VECI;
                end
            end
            odtp_pkg::S_ROT: begin
                o_cmd.op = odtp_pkg::OP_ITER;
                n_iter = r_iter + 5'd1;
                if (r_iter == 5'(NS - 1)) begin
                    n_state = (r_sub == 3'd1) ? odtp_pkg::S_EFF : odtp_pkg::S_POSE;
                    n_sub = '0;
                end
            end
            odtp_pkg::S_POSE: begin
                o_cmd.op = odtp_pkg::OP_POSE;
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd2) begin
                    n_sub = '0;
                    n_state = odtp_pkg::S_VECI;
                end
            end
            odtp_pkg::S_VECI: begin
                o_cmd.op = odtp_pkg::OP_VEC_INIT;
                n_iter = '0;
                n_state = odtp_pkg::S_VEC;
            end
            odtp_pkg::S_VEC: begin
                o_cmd.op = odtp_pkg::OP_ITER;
                o_cmd.vec_mode = 1'b1;
                n_iter = r_iter + 5'd1;
                if (r_iter == 5'(NS - 1)) begin
                    n_state = odtp_pkg::S_MAG;
                    n_sub = '0;
                end
            end
            odtp_pkg::S_MAG: begin
                o_cmd.op = odtp_pkg::OP_MAG;
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd1) begin
                    n_sub = '0;
                    n_state = (i_stat.kind && i_stat.driving) ? odtp_pkg::S_ERRI
                                                              : odtp_pkg::S_OUT;
                end
            end
            odtp_pkg::S_ERRI: begin
                o_cmd.op = odtp_pkg::OP_ROT_INIT_ERR;
                n_iter = '0;
                n_sub = 3'd1;
                n_state = odtp_pkg::S_ROT;
            end
            odtp_pkg::S_EFF: begin
                o_cmd.op = odtp_pkg::OP_EFF;
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd3) begin
                    n_sub = '0;
                    n_state = odtp_pkg::S_OUT;
                end
            end
            odtp_pkg::S_OUT: begin
                n_ovalid = 1'b1;
                n_state = odtp_pkg::S_IDLE;
            end
            default: n_state = odtp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= odtp_pkg::S_IDLE;
            r_iter   <= '0;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_iter   <= n_iter;
            r_sub    <= n_sub;
            r_ovalid <= n_ovalid;
        end
    end

    logic unused_zero;
    assign unused_zero = i_stat.zero_vec;

endmodule

// ----- rtl/odtp_dp.sv -----
module odtp_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  odtp_pkg::t_cmd        i_cmd,
    output odtp_pkg::t_status     o_stat,
    input  logic                  i_kind,
    input  logic signed [11:0]    i_step_distance,
    input  logic signed [12:0]    i_turn_angle,
    input  logic signed [23:0]    i_goal_x,
    input  logic signed [23:0]    i_goal_y,
    input  logic [7:0]            i_dist_gain,
    input  logic [15:0]           i_head_gain,
    input  logic [7:0]            i_eff_limit,
    input  logic [15:0]           i_reach,
    output logic signed [8:0]     o_left_drive,
    output logic signed [8:0]     o_right_drive,
    output logic                  o_at_goal,
    output logic                  o_is_driving,
    output logic signed [23:0]    o_now_x,
    output logic signed [23:0]    o_now_y,
    output logic signed [15:0]    o_now_heading,
    output logic [15:0]           o_laps
);
    localparam int AW = odtp_pkg::AW;
    localparam int DW = odtp_pkg::DW;

    logic signed [23:0] r_pos_x, r_pos_y, r_tgt_x, r_tgt_y;
    logic signed [15:0] r_head;
    logic [15:0]        r_laps;
    logic               r_drv;

    logic               r_kind;
    logic signed [11:0] r_step;
    logic signed [12:0] r_turn;

    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_z;
    logic                 r_neg, r_zero;

    logic signed [63:0]    r_prod;
    logic signed [25:0]    r_mag;
    logic signed [15:0]    r_err;
    logic signed [17:0]    r_cq16;
    logic signed [63:0]    r_fwd, r_trn;
    logic signed [31:0]    r_tp;
    logic signed [8:0]     r_left, r_right;
    logic                  r_at;

    // angle fold for rotation mode: 16-bit binary angle scaled to 32 bits
    function automatic logic signed [AW-1:0] fold(input logic signed [15:0] a, output logic ng);
        logic signed [AW-1:0] z;
        z = AW'(a) <<< 16;
        ng = 1'b0;
        if (z > (AW'(1) <<< 30)) begin
            z = z - (AW'(1) <<< 31);
            ng = 1'b1;
        end else if (z < -(AW'(1) <<< 30)) begin
            z = z + (AW'(1) <<< 31);
            ng = 1'b1;
        end
        return z;
    endfunction

    logic signed [12:0] w_h1, w_h2;
    logic signed [15:0] w_mid;
    logic signed [16:0] w_full;
    assign w_h1   = r_turn >>> 1;
    assign w_h2   = r_turn - w_h1;
    assign w_mid  = r_head + 16'(w_h1);
    assign w_full = 17'(r_head) + 17'(w_h1) + 17'(w_h2);

    logic signed [DW-1:0] w_sx, w_sy;
    logic signed [AW-1:0] w_at;
    logic                 w_dir;
    assign w_sx  = r_x >>> i_cmd.iter;
    assign w_sy  = r_y >>> i_cmd.iter;
    assign w_at  = odtp_pkg::atan_rom(i_cmd.iter);
    assign w_dir = i_cmd.vec_mode ? (r_y > 0) : (r_z >= 0);

    logic signed [24:0] w_dx, w_dy;
    assign w_dx = 25'(r_tgt_x) - 25'(r_pos_x);
    assign w_dy = 25'(r_tgt_y) - 25'(r_pos_y);

    logic signed [DW-1:0] w_c, w_s;
    assign w_c = r_neg ? -r_x : r_x;
    assign w_s = r_neg ? -r_y : r_y;

    logic signed [AW-1:0] w_zr;
    logic [15:0]          w_bear;
    assign w_zr   = (r_z + AW'(32768)) >>> 16;
    assign w_bear = r_zero ? 16'd0 : w_zr[15:0];

    logic signed [DW-1:0] w_ca;
    assign w_ca = w_c[DW-1] ? -w_c : w_c;

    logic signed [63:0] w_lim;
    assign w_lim = 64'(signed'({1'b0, i_eff_limit})) <<< 24;

    function automatic logic signed [8:0] sat(input logic signed [63:0] v,
                                              input logic signed [63:0] lim,
                                              input logic [7:0] l);
        logic signed [63:0] a;
        a = v[63] ? -v : v;
        if (v > lim) return 9'(signed'({1'b0, l}));
        if (v < -lim) return -9'(signed'({1'b0, l}));
        return v[63] ? -9'(a >>> 24) : 9'(v >>> 24);
    endfunction

    logic w_ng;
    logic signed [AW-1:0] w_fz;

    always_comb begin
        w_fz = fold((i_cmd.op == odtp_pkg::OP_ROT_INIT_MID) ? w_mid : r_err, w_ng);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0; r_pos_y <= '0; r_tgt_x <= '0; r_tgt_y <= '0;
            r_head <= '0; r_laps <= '0; r_drv <= 1'b0;
        end else begin
            if (i_cmd.load_goal) begin
                r_kind <= i_kind;
                r_step <= i_step_distance;
                r_turn <= i_turn_angle;
                if (!i_kind) begin
                    r_tgt_x <= i_goal_x;
                    r_tgt_y <= i_goal_y;
                    r_drv   <= 1'b1;
                end
            end
            case (i_cmd.op)
                odtp_pkg::OP_ROT_INIT_MID, odtp_pkg::OP_ROT_INIT_ERR: begin
                    r_x   <= DW'(odtp_pkg::KQ30);
                    r_y   <= '0;
                    r_z   <= w_fz;
                    r_neg <= w_ng;
                end
                odtp_pkg::OP_ITER: begin
                    if (w_dir == i_cmd.vec_mode) begin
                        r_x <= r_x + w_sy; r_y <= r_y - w_sx;
                        r_z <= i_cmd.vec_mode ? r_z + w_at : r_z + w_at;
                    end else begin
                        r_x <= r_x - w_sy; r_y <= r_y + w_sx;
                        r_z <= r_z - w_at;
                    end
                end
                odtp_pkg::OP_POSE: begin
                    case (i_cmd.sub)
                        3'd0: r_prod <= 64'(r_step) * 64'(w_c);
                        3'd1: begin
                            r_pos_x <= r_pos_x + 24'((r_prod + 64'(1 <<< 29)) >>> 30);
                            r_prod  <= 64'(r_step) * 64'(w_s);
                        end
                        default: begin
                            r_pos_y <= r_pos_y + 24'((r_prod + 64'(1 <<< 29)) >>> 30);
                            r_head  <= w_full[15:0];
                            if (w_full >= 17'sd32768) r_laps <= r_laps + 16'd1;
                        end
                    endcase
                end
                odtp_pkg::OP_VEC_INIT: begin
                    r_zero <= (w_dx == 0) && (w_dy == 0);
                    if (w_dx < 0) begin
                        r_x <= -(DW'(w_dx) <<< 6);
                        r_y <= -(DW'(w_dy) <<< 6);
                        r_z <= (w_dy >= 0) ? (AW'(1) <<< 31) : -(AW'(1) <<< 31);
                    end else begin
                        r_x <= DW'(w_dx) <<< 6;
                        r_y <= DW'(w_dy) <<< 6;
                        r_z <= '0;
                    end
                end
                odtp_pkg::OP_MAG: begin
                    if (i_cmd.sub == 3'd0) begin
                        r_prod <= 64'(r_x[31:0]) * 64'(odtp_pkg::KQ30);
                    end else begin
                        r_mag <= r_zero ? 26'sd0
                               : 26'((r_prod + 64'(64'sd1 <<< 35)) >>> 36);
                        r_at  <= r_zero ? (i_reach != 0)
                               : (26'((r_prod + 64'(64'sd1 <<< 35)) >>> 36)
                                  < 26'(signed'({1'b0, i_reach})));
                        r_err <= w_bear - r_head;
                        r_left <= '0; r_right <= '0;
                    end
                end
                odtp_pkg::OP_EFF: begin
                    case (i_cmd.sub)
                        3'd0: begin
                            r_cq16 <= 18'(w_ca >>> 14);
                            r_tp   <= 32'(r_err) * 32'(signed'({1'b0, i_head_gain}));
                        end
                        3'd1: begin
                            r_fwd <= 64'(r_mag) * 64'(signed'({1'b0, i_dist_gain}));
                            r_trn <= (64'(r_tp) * 64'(odtp_pkg::PiQ24)) >>> 15;
                        end
                        3'd2: r_fwd <= r_fwd * 64'(r_cq16);
                        default: begin
                            r_left  <= sat(r_fwd - r_trn, w_lim, i_eff_limit);
                            r_right <= sat(r_fwd + r_trn, w_lim, i_eff_limit);
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.driving  = r_drv;
    assign o_stat.zero_vec = r_zero;

    assign o_left_drive  = r_left;
    assign o_right_drive = r_right;
    assign o_at_goal     = r_at;
    assign o_is_driving  = r_drv;
    assign o_now_x       = r_pos_x;
    assign o_now_y       = r_pos_y;
    assign o_now_heading = r_head;
    assign o_laps        = r_laps;

endmodule

// ----- tb/odtp_checker.sv -----
module odtp_checker #(
    parameter int CORDIC_STAGES = odtp_pkg::CordicStagesDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_kind,
    input  logic signed [11:0] i_step_distance,
    input  logic signed [12:0] i_turn_angle,
    input  logic signed [23:0] i_goal_x,
    input  logic signed [23:0] i_goal_y,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [8:0]  o_left_drive,
    input  logic signed [8:0]  o_right_drive,
    input  logic               o_at_goal,
    input  logic               o_is_driving,
    input  logic signed [23:0] o_now_x,
    input  logic signed [23:0] o_now_y,
    input  logic signed [15:0] o_now_heading,
    input  logic [15:0]        o_laps,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    localparam int Stages = CORDIC_STAGES > 24 ? 24 : (CORDIC_STAGES < 1 ? 1 : CORDIC_STAGES);
    localparam longint AngPi = 64'sd2147483648;
    localparam longint KGain = 64'sd652032874;
    localparam longint PiFix = 64'sd52707179;

    localparam longint ArcTan [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    typedef struct {
        logic signed [8:0]  left;
        logic signed [8:0]  right;
        logic               at_goal;
        logic               driving;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] heading;
        logic [15:0]        laps;
    } drive_result_t;

    drive_result_t expected_results[$];

    logic [7:0]         dist_gain;
    logic [15:0]        head_gain;
    logic [7:0]         eff_limit;
    logic [15:0]        reach;
    logic signed [23:0] pose_x, pose_y, goal_x, goal_y;
    logic [15:0]        pose_heading, lap_count;
    logic               in_drive;

    function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
        longint z, x, y, t;
        bit     flip;
        z = longint'($signed(ang));
        flip = 0;
        x = KGain;
        y = 0;
        if (z > AngPi / 2) begin
            z -= AngPi;
            flip = 1;
        end else if (z < -AngPi / 2) begin
            z += AngPi;
            flip = 1;
        end
        for (int i = 0; i < Stages; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i); y = y + (x >>> i); z -= ArcTan[i];
            end else begin
                t = x + (y >>> i); y = y - (x >>> i); z += ArcTan[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // range (1/256 cm) and bearing (16-bit angle) of a vector
    function automatic void vectorize(input longint dx, input longint dy,
                                      output longint mag, output logic [15:0] bear);
        longint x, y, z, t;
        x = dx * 64;
        y = dy * 64;
        z = 0;
        if (dx == 0 && dy == 0) begin
            mag = 0;
            bear = '0;
            return;
        end
        if (x < 0) begin
            z = (y >= 0) ? AngPi : -AngPi;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < Stages; i++) begin
            if (y > 0) begin
                t = x + (y >>> i); y = y - (x >>> i); z += ArcTan[i];
            end else begin
                t = x - (y >>> i); y = y + (x >>> i); z -= ArcTan[i];
            end
            x = t;
        end
        mag = (x * KGain + (64'sd1 <<< 35)) >>> 36;
        bear = 16'((z + 32768) >>> 16);
    endfunction

    function automatic longint clip_effort(input longint v);
        longint lim;
        lim = longint'(eff_limit);
        if (v > lim * (64'sd1 <<< 24)) return lim;
        if (v < -lim * (64'sd1 <<< 24)) return -lim;
        return v >= 0 ? (v >>> 24) : -((-v) >>> 24);
    endfunction

    function automatic drive_result_t advance_pose_and_drive(
        input logic kind, input logic signed [11:0] step_in,
        input logic signed [12:0] turn_in, input logic signed [23:0] gx,
        input logic signed [23:0] gy);
        drive_result_t      r;
        longint             step, turn, h1, hs, full, c, s, mag, err, cq16, fwd, trn;
        logic [15:0]        mid, bear;
        logic signed [15:0] err16;
        r.left = '0;
        r.right = '0;
        if (!kind) begin
            goal_x = gx;
            goal_y = gy;
            in_drive = 1'b1;
        end else begin
            step = step_in;
            turn = turn_in;
            h1 = turn >>> 1;
            hs = longint'($signed(pose_heading));
            mid = 16'(hs + h1);
            rotate({mid, 16'h0}, c, s);
            pose_x = 24'(longint'(pose_x) + ((step * c + (64'sd1 <<< 29)) >>> 30));
            pose_y = 24'(longint'(pose_y) + ((step * s + (64'sd1 <<< 29)) >>> 30));
            full = hs + turn;
            if (full >= 32768) lap_count = lap_count + 16'd1;
            pose_heading = 16'(full);
        end
        vectorize(longint'(goal_x) - longint'(pose_x), longint'(goal_y) - longint'(pose_y),
                  mag, bear);
        r.at_goal = mag < longint'(reach);
        if (in_drive && kind) begin
            err16 = bear - pose_heading;
            err = err16;
            rotate({err16, 16'h0}, c, s);
            if (c < 0) c = -c;
            cq16 = c >>> 14;
            fwd = mag * longint'(dist_gain) * cq16;
            trn = (err * longint'(head_gain) * PiFix) >>> 15;
            r.left = 9'(clip_effort(fwd - trn));
            r.right = 9'(clip_effort(fwd + trn));
        end
        r.driving = in_drive;
        r.x = pose_x;
        r.y = pose_y;
        r.heading = pose_heading;
        r.laps = lap_count;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        drive_result_t want;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            dist_gain <= odtp_pkg::DistGainRst;
            head_gain <= odtp_pkg::HeadGainRst;
            eff_limit <= odtp_pkg::EffLimitRst;
            reach <= odtp_pkg::ReachRst;
            pose_x = '0; pose_y = '0; goal_x = '0; goal_y = '0;
            pose_heading = '0; lap_count = '0; in_drive = 1'b0;
            expected_results.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    odtp_pkg::RegDistGain: dist_gain <= i_cfg_data[7:0];
                    odtp_pkg::RegHeadGain: head_gain <= i_cfg_data;
                    odtp_pkg::RegEffLimit: eff_limit <= i_cfg_data[7:0];
                    odtp_pkg::RegReach:    reach <= i_cfg_data;
                    default: ;
                endcase
            end
            // results leaving this edge belong to earlier input transfers
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_left_drive !== want.left) begin
                        $error("left_drive exp %0d got %0d", want.left, o_left_drive);
                        errs++;
                    end
                    if (o_right_drive !== want.right) begin
                        $error("right_drive exp %0d got %0d", want.right, o_right_drive);
                        errs++;
                    end
                    if (o_at_goal !== want.at_goal) begin
                        $error("at_goal exp %0d got %0d", want.at_goal, o_at_goal);
                        errs++;
                    end
                    if (o_is_driving !== want.driving) begin
                        $error("is_driving exp %0d got %0d", want.driving, o_is_driving);
                        errs++;
                    end
                    if (o_now_x !== want.x) begin
                        $error("now_x exp %0d got %0d", want.x, o_now_x);
                        errs++;
                    end
                    if (o_now_y !== want.y) begin
                        $error("now_y exp %0d got %0d", want.y, o_now_y);
                        errs++;
                    end
                    if (o_now_heading !== want.heading) begin
                        $error("now_heading exp %0d got %0d", want.heading, o_now_heading);
                        errs++;
                    end
                    if (o_laps !== want.laps) begin
                        $error("laps exp %0d got %0d", want.laps, o_laps);
                        errs++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_results.push_back(advance_pose_and_drive(
                    i_kind, i_step_distance, i_turn_angle, i_goal_x, i_goal_y));
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_kind = 1'b1;
    logic signed [11:0] i_step_distance = '0;
    logic signed [12:0] i_turn_angle = '0;
    logic signed [23:0] i_goal_x = '0;
    logic signed [23:0] i_goal_y = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [8:0]  o_left_drive, o_right_drive;
    logic               o_at_goal, o_is_driving;
    logic signed [23:0] o_now_x, o_now_y;
    logic signed [15:0] o_now_heading;
    logic [15:0]        o_laps;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;
    int                 mismatches, outstanding;
    int                 items_sent = 0, goals_sent = 0;
    logic signed [23:0] seen_x = '0, seen_y = '0;
    bit                 no_stall = 0;
    int                 stall_left = 0;

    odometry_drive_to_point DUT (.*);
    odtp_checker u_checker (.*, .o_errors(mismatches), .o_pending(outstanding));

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #(12 * 3_000_000);
        $display("timeout");
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 60);
    endfunction

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (no_stall) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            i_ready <= (stall_left == 0);
        end
        if (o_valid && i_ready) begin
            seen_x <= o_now_x;
            seen_y <= o_now_y;
        end
    end

    task automatic send(input logic kind, input logic signed [11:0] step,
                        input logic signed [12:0] turn, input logic signed [23:0] gx,
                        input logic signed [23:0] gy);
        int gap;
        i_kind <= kind;
        i_step_distance <= step;
        i_turn_angle <= turn;
        i_goal_x <= gx;
        i_goal_y <= gy;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (!kind) goals_sent++;
        gap = no_stall ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // goal close to the pose so the reach test flips both ways
            send(1'b0, 12'($urandom), 13'($urandom),
                 seen_x + 24'($signed(12'($urandom))), seen_y + 24'($signed(12'($urandom))));
        end else if (r < 14) begin
            send(1'b0, 12'($urandom), 13'($urandom), 24'($urandom), 24'($urandom));
        end else if (r < 17) begin
            send(1'b0, 12'($urandom), 13'($urandom),
                 seen_x + 24'($signed(16'($urandom))), seen_y + 24'($signed(16'($urandom))));
        end else begin
            send(1'b1, 12'($urandom), 13'($urandom), 24'($urandom), 24'($urandom));
        end
    endtask

    initial begin
        logic [15:0] gains [5][4];
        gains = '{'{16'd255, 16'd65535, 16'd255, 16'd65535},
                  '{16'd0, 16'd0, 16'd0, 16'd0},
                  '{16'd1, 16'd1, 16'd1, 16'd4096},
                  '{16'd20, 16'd2000, 16'd150, 16'd768},
                  '{16'd7, 16'd300, 16'd40, 16'd20000}};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // motion while idle, then a goal at the origin
        send(1'b1, 12'sd2047, 13'sd4095, 24'sd0, 24'sd0);
        send(1'b1, -12'sd2048, -13'sd4096, 24'sd0, 24'sd0);
        send(1'b1, 12'sd0, 13'sd1, 24'sd0, 24'sd0);
        send(1'b0, 12'sd0, 13'sd0, 24'sd0, 24'sd0);
        send(1'b1, 12'sd0, 13'sd0, 24'sd0, 24'sd0);
        send(1'b0, 12'sd0, 13'sd0, 24'sd8388607, 24'sd8388607);
        send(1'b1, 12'sd2047, 13'sd0, 24'sd0, 24'sd0);
        send(1'b0, 12'sd0, 13'sd0, -24'sd8388608, -24'sd8388608);
        send(1'b1, -12'sd2048, 13'sd0, 24'sd0, 24'sd0);
        send(1'b0, 12'sd0, 13'sd0, 24'sd200, -24'sd100);
        // spin forward past +pi, then back
        repeat (9) send(1'b1, 12'sd100, 13'sd4095, 24'sd0, 24'sd0);
        repeat (4) send(1'b1, 12'sd5, -13'sd4096, 24'sd0, 24'sd0);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 5) begin
                for (int k = 0; k < 4; k++) write_reg(2'(k), gains[ph][k]);
            end else begin
                write_reg(odtp_pkg::RegDistGain, 16'($urandom));
                write_reg(odtp_pkg::RegHeadGain, 16'($urandom));
                write_reg(odtp_pkg::RegEffLimit, 16'($urandom));
                write_reg(odtp_pkg::RegReach, 16'($urandom));
            end
            no_stall = (ph == 2);
            repeat (245) random_item();
            settle();
        end

        $display("covered %0d items (%0d goal updates) over 7 register settings",
                 items_sent, goals_sent);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
